### hw/rtl/lru_sac_pkg.sv
// shared types, codes and defaults for the lru set-associative cache tracker
package lru_sac_pkg;

   // defaults for the top-level parameters
   localparam int DEF_ADDR_WIDTH = 64;
   localparam int DEF_MAX_SETS   = 64;
   localparam int DEF_MAX_WAYS   = 8;

   // configuration port
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // register indexes (word address within the port)
   localparam logic [1:0] CSR_SET_BITS    = 2'd0;
   localparam logic [1:0] CSR_OFFSET_BITS = 2'd1;
   localparam logic [1:0] CSR_WAYS        = 2'd2;

   // register reset values
   localparam logic [2:0] SET_BITS_RST    = 3'd4;
   localparam logic [4:0] OFFSET_BITS_RST = 5'd4;
   localparam logic [3:0] WAYS_RST        = 4'd1;

   // set field is at most seven bits wide
   localparam int SET_FIELD_W    = 7;
   localparam int SET_FIELD_SPAN = 128;

   // operation codes
   localparam logic [1:0] OP_LOAD   = 2'd0;
   localparam logic [1:0] OP_STORE  = 2'd1;
   localparam logic [1:0] OP_MODIFY = 2'd2;

   // result status codes
   localparam logic [1:0] STATUS_HIT   = 2'd0;
   localparam logic [1:0] STATUS_FILL  = 2'd1;
   localparam logic [1:0] STATUS_EVICT = 2'd2;

   typedef struct packed {
      logic [1:0]  operation;
      logic [63:0] address;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic        last;
      logic [31:0] hit_count;
      logic [31:0] miss_count;
      logic [31:0] eviction_count;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_LOAD,
      ST_SCAN,
      ST_UPDATE
   } state_type;

endpackage

### hw/rtl/lru_set_assoc_cache_tracker_core.sv
// tag-only set-associative cache tracker with true lru replacement
// Usage: after reset the block runs a clearing pass over the set memory, one set per cycle,
// during which req_ready is low (configuration writes still work). A load or store item then
// runs through these steps: accept and split the address, read the set row from memory, load
// it, compare the W ways in use one per cycle in the single tag comparator, and pick hit or
// victim, rewrite the row and present the result. A modify item runs the way scan and update
// a second time on the held row and gives two items. The update waits while the previous
// result is still held on the output. Operation code three is taken and dropped with no
// result.
module lru_set_assoc_cache_tracker_core #(
   parameter int ADDR_WIDTH = lru_sac_pkg::DEF_ADDR_WIDTH,
   parameter int MAX_SETS   = lru_sac_pkg::DEF_MAX_SETS,
   parameter int MAX_WAYS   = lru_sac_pkg::DEF_MAX_WAYS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  lru_sac_pkg::req_type                req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output lru_sac_pkg::rsp_type                rsp_data,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [lru_sac_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [lru_sac_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [lru_sac_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                                csr_pready
);
   import lru_sac_pkg::*;

   localparam int RANK_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int SEL_W  = RANK_W + 1;
   localparam int SET_W  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;

   typedef struct packed {
      logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0] tag;
      logic [MAX_WAYS-1:0]                 valid;
      logic [MAX_WAYS-1:0][RANK_W-1:0]     rank;
   } row_type;

   // state and control
   state_type state_ff, state_in;
   logic      clr_en, load_en, scan_en, upd_go, acc_go;
   logic      is_access;

   // configuration registers
   logic [2:0] sib_ff, sib_in;
   logic [4:0] bob_ff, bob_in;
   logic [3:0] ways_ff, ways_in;
   logic       csr_wr;

   // item registers
   logic [1:0]            op_ff, op_in;
   logic                  pass_ff, pass_in;
   logic [ADDR_WIDTH-1:0] tag_ff, tag_in;
   logic [SET_W-1:0]      set_ff, set_in;
   logic [SET_W-1:0]      clr_ff, clr_in;

   // set memory and working row
   row_type mem_ff [MAX_SETS];
   row_type rd_data_ff;
   row_type row_ff, row_in;
   row_type row_upd, rst_row, mem_wdata;
   logic [SET_W-1:0] mem_waddr;

   // scan trackers
   logic [RANK_W-1:0] way_ff, way_in, ways_last;
   logic [SEL_W-1:0]  stop_ff, stop_in, best_ff, best_in;
   logic [RANK_W-1:0] hit_way_ff, hit_way_in;
   logic [RANK_W-1:0] vrank_ff, vrank_in, vway_ff, vway_in;

   // counters and result register
   logic [31:0] hits_ff, hits_in, misses_ff, misses_in, evicts_ff, evicts_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;

   // address split
   logic [ADDR_WIDTH-1:0]  addr_n, set_shift;
   logic [5:0]             span;
   logic [7:0]             smask_w;
   logic [SET_FIELD_W-1:0] set_field;
   logic [SET_W-1:0]       set_lut [SET_FIELD_SPAN];

   // scan datapath
   logic [ADDR_WIDTH-1:0] cur_tag;
   logic                  cur_valid;
   logic [RANK_W-1:0]     cur_rank;

   // update datapath
   logic              hit;
   logic [RANK_W-1:0] tgt_way, tgt_rank;
   logic [1:0]        upd_status;

   // set index wrap table, built at elaboration
   for (genvar g = 0; g < SET_FIELD_SPAN; g++) begin : g_set_lut
      assign set_lut[g] = SET_W'(g % MAX_SETS);
   end

   assign is_access = (req_data.operation == OP_LOAD) || (req_data.operation == OP_STORE) ||
                      (req_data.operation == OP_MODIFY);
   assign acc_go    = req_valid && req_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == SET_W'(MAX_SETS - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid && is_access) state_in = ST_READ;
         end
         ST_READ:  state_in = ST_LOAD;
         ST_LOAD:  state_in = ST_SCAN;
         ST_SCAN: begin
            if (way_ff == ways_last) state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (upd_go) state_in = (op_ff == OP_MODIFY && !pass_ff) ? ST_SCAN : ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_ready = 1'b0;
      clr_en    = 1'b0;
      load_en   = 1'b0;
      scan_en   = 1'b0;
      upd_go    = 1'b0;
      unique case (state_ff)
         ST_CLEAR:  clr_en = 1'b1;
         ST_IDLE:   req_ready = 1'b1;
         ST_READ: begin
         end
         ST_LOAD:   load_en = 1'b1;
         ST_SCAN:   scan_en = 1'b1;
         ST_UPDATE: upd_go = !rsp_valid_ff || rsp_ready;
         default: begin
         end
      endcase
   end

   // configuration write and read
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      sib_in  = sib_ff;
      bob_in  = bob_ff;
      ways_in = ways_ff;
      if (csr_wr) begin
         unique case (csr_paddr[3:2])
            CSR_SET_BITS:    sib_in  = csr_pwdata[2:0];
            CSR_OFFSET_BITS: bob_in  = csr_pwdata[4:0];
            CSR_WAYS:        ways_in = csr_pwdata[3:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         CSR_SET_BITS:    csr_prdata = CSR_DATA_W'(sib_ff);
         CSR_OFFSET_BITS: csr_prdata = CSR_DATA_W'(bob_ff);
         CSR_WAYS:        csr_prdata = CSR_DATA_W'(ways_ff);
         default:         csr_prdata = '0;
      endcase
   end

   // ways in use, clamped to one..MAX_WAYS, as last way index
   always_comb begin
      if (ways_ff == 4'd0) ways_last = '0;
      else if (int'(ways_ff) > MAX_WAYS) ways_last = RANK_W'(MAX_WAYS - 1);
      else ways_last = RANK_W'(ways_ff - 4'd1);
   end

   // address split into tag and wrapped set index
   always_comb begin
      addr_n    = req_data.address[ADDR_WIDTH-1:0];
      span      = 6'(sib_ff) + 6'(bob_ff);
      set_shift = addr_n >> bob_ff;
      smask_w   = (8'd1 << sib_ff) - 8'd1;
      set_field = set_shift[SET_FIELD_W-1:0] & smask_w[SET_FIELD_W-1:0];
   end

   // item registers
   always_comb begin
      op_in   = op_ff;
      tag_in  = tag_ff;
      set_in  = set_ff;
      pass_in = pass_ff;
      if (acc_go) begin
         op_in   = req_data.operation;
         tag_in  = addr_n >> span;
         set_in  = set_lut[set_field];
         pass_in = 1'b0;
      end else if (upd_go) begin
         pass_in = 1'b1;
      end
   end

   // clearing pass counter
   assign clr_in = clr_en ? clr_ff + SET_W'(1) : clr_ff;

   // reset row: all invalid, rank equals way number
   always_comb begin
      rst_row = '0;
      for (int w = 0; w < MAX_WAYS; w++) rst_row.rank[w] = RANK_W'(w);
   end

   // shared compare unit: one way per cycle
   always_comb begin
      cur_tag   = row_ff.tag[way_ff];
      cur_valid = row_ff.valid[way_ff];
      cur_rank  = row_ff.rank[way_ff];
      way_in     = way_ff;
      stop_in    = stop_ff;
      best_in    = best_ff;
      hit_way_in = hit_way_ff;
      vrank_in   = vrank_ff;
      vway_in    = vway_ff;
      if (load_en || upd_go) begin
         way_in   = '0;
         stop_in  = '1;
         best_in  = '1;
         vrank_in = '0;
         vway_in  = '0;
      end else if (scan_en) begin
         way_in = way_ff + RANK_W'(1);
         // lowest rank among invalid lines ends the search
         if (!cur_valid && {1'b0, cur_rank} < stop_ff) stop_in = {1'b0, cur_rank};
         // most recent matching line
         if (cur_valid && cur_tag == tag_ff && {1'b0, cur_rank} < best_ff) begin
            best_in    = {1'b0, cur_rank};
            hit_way_in = way_ff;
         end
         // least recent line is the victim
         if (cur_rank >= vrank_ff) begin
            vrank_in = cur_rank;
            vway_in  = way_ff;
         end
      end
   end

   // hit or install, then move the line to mru
   always_comb begin
      hit      = best_ff < stop_ff;
      tgt_way  = hit ? hit_way_ff : vway_ff;
      tgt_rank = hit ? best_ff[RANK_W-1:0] : vrank_ff;
      if (hit) upd_status = STATUS_HIT;
      else if (row_ff.valid[vway_ff]) upd_status = STATUS_EVICT;
      else upd_status = STATUS_FILL;
      row_upd = row_ff;
      if (!hit) row_upd.tag[vway_ff] = tag_ff;
      row_upd.valid[tgt_way] = 1'b1;
      for (int w = 0; w < MAX_WAYS; w++) begin
         if (row_ff.rank[w] < tgt_rank) row_upd.rank[w] = row_ff.rank[w] + RANK_W'(1);
      end
      row_upd.rank[tgt_way] = '0;
   end

   // working row
   always_comb begin
      if (load_en) row_in = rd_data_ff;
      else if (upd_go) row_in = row_upd;
      else row_in = row_ff;
   end

   // saturating counters
   always_comb begin
      hits_in   = hits_ff;
      misses_in = misses_ff;
      evicts_in = evicts_ff;
      if (upd_go) begin
         if (upd_status == STATUS_HIT) begin
            if (hits_ff != '1) hits_in = hits_ff + 32'd1;
         end else begin
            if (misses_ff != '1) misses_in = misses_ff + 32'd1;
         end
         if (upd_status == STATUS_EVICT && evicts_ff != '1) evicts_in = evicts_ff + 32'd1;
      end
   end

   // result register
   always_comb begin
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (upd_go) begin
         rsp_valid_in               = 1'b1;
         rsp_data_in.status         = upd_status;
         rsp_data_in.last           = !(op_ff == OP_MODIFY && !pass_ff);
         rsp_data_in.hit_count      = hits_in;
         rsp_data_in.miss_count     = misses_in;
         rsp_data_in.eviction_count = evicts_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // memory write port: clearing pass or row write-back
   assign mem_waddr = clr_en ? clr_ff : set_ff;
   assign mem_wdata = clr_en ? rst_row : row_upd;

   // set memory, one row per set
   always_ff @(posedge clock) begin
      if (clr_en || upd_go) mem_ff[mem_waddr] <= mem_wdata;
      rd_data_ff <= mem_ff[set_ff];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         sib_ff       <= SET_BITS_RST;
         bob_ff       <= OFFSET_BITS_RST;
         ways_ff      <= WAYS_RST;
         pass_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         hits_ff      <= '0;
         misses_ff    <= '0;
         evicts_ff    <= '0;
         way_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         sib_ff       <= sib_in;
         bob_ff       <= bob_in;
         ways_ff      <= ways_in;
         pass_ff      <= pass_in;
         rsp_valid_ff <= rsp_valid_in;
         hits_ff      <= hits_in;
         misses_ff    <= misses_in;
         evicts_ff    <= evicts_in;
         way_ff       <= way_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      tag_ff      <= tag_in;
      set_ff      <= set_in;
      row_ff      <= row_in;
      stop_ff     <= stop_in;
      best_ff     <= best_in;
      hit_way_ff  <= hit_way_in;
      vrank_ff    <= vrank_in;
      vway_ff     <= vway_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule
